FILE: rtl/canmob_pkg.sv
// ----------------------------------------------------------------------------
// canmob_pkg: shared types for the CAN message object bank
// Entry layout, operation and event codes, and the cell-to-cell structs.
// ----------------------------------------------------------------------------
package canmob_pkg;

  localparam int unsigned ID_W   = 11;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned MOB_W  = 3;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned EV_W   = 3;
  localparam int unsigned CELL_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_SELECT = 3'd0,
    OP_CONFIG = 3'd1,
    OP_ID     = 3'd2,
    OP_MASK   = 3'd3,
    OP_DATA   = 3'd4,
    OP_RECV   = 3'd5,
    OP_QUERY  = 3'd6
  } op_e;

  typedef enum logic [EV_W-1:0] {
    EV_DONE = 3'd0,
    EV_TX   = 3'd1,
    EV_HIT  = 3'd2,
    EV_MISS = 3'd3,
    EV_SEND = 3'd4
  } event_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF = 2'd0,
    MODE_TX  = 2'd1,
    MODE_RX  = 2'd2,
    MODE_BUF = 2'd3
  } mode_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   mask;
    logic [LEN_W-1:0]  length;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  index;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic [MOB_W-1:0] sel_mob;
    logic [ID_W-1:0]  rx_id;
  } req_t;

  typedef struct packed {
    logic             we;
    logic [MOB_W-1:0] page;
    entry_t           entry;
  } commit_t;

  // passed from cell to cell
  typedef struct packed {
    logic              found;
    logic [CELL_W-1:0] idx;
    entry_t            sel;
  } chain_t;

endpackage

FILE: rtl/canmob_cell.sv
// ----------------------------------------------------------------------------
// canmob_cell: one message object
// Holds one entry, takes commits for its page, adds itself to the
// first-match receive chain and to the select read chain.
// ----------------------------------------------------------------------------
module canmob_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  canmob_pkg::req_t    req_i,
  input  canmob_pkg::commit_t commit_i,
  input  canmob_pkg::chain_t  chain_i,
  output canmob_pkg::chain_t  chain_o
);

  canmob_pkg::entry_t entry_q, entry_d;
  logic               match;
  logic               selected;

  assign selected = (int'(req_i.sel_mob) == int'(Idx));
  assign match = (entry_q.mode == canmob_pkg::MODE_RX) &&
                 ((req_i.rx_id & entry_q.mask) == (entry_q.id & entry_q.mask));

  always_comb begin
    entry_d = entry_q;
    if (commit_i.we && (int'(commit_i.page) == int'(Idx))) begin
      entry_d = commit_i.entry;
    end
  end

  always_comb begin
    chain_o = chain_i;
    if (!chain_i.found && match) begin
      chain_o.found = 1'b1;
      chain_o.idx   = canmob_pkg::CELL_W'(Idx);
    end
    if (selected) begin
      chain_o.sel = entry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

FILE: rtl/can_message_object_bank.sv
// ----------------------------------------------------------------------------
// can_message_object_bank: paged bank of CAN message objects
// Path: the item register loads at input accept; once the output register is
// free or being drained, one pass through the row of object cells loads the
// output register. A stalled output holds the item in the item register.
// A new item is taken only after the single item register has emptied.
// Reset: all objects, the view, page, busy flag cleared; auto increment on.
// ----------------------------------------------------------------------------
module can_message_object_bank #(
  parameter int unsigned NUM_OBJECTS = 6,
  parameter int unsigned DATA_BYTES  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // mob_number[2:0], mode_bits[4:3], frame_length[8:5], frame_id[19:9],
  // mask_value[30:20]
  input  logic [31:0] s_axis_tdata,
  // operation[2:0]
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // hit_mob[2:0], out_id[13:3], out_length[17:14], tx_busy[18],
  // view_index[21:19]
  output logic [23:0] m_axis_tdata,
  // event_res[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdW  = canmob_pkg::ID_W;
  localparam int unsigned LenW = canmob_pkg::LEN_W;
  localparam int unsigned IxW  = canmob_pkg::IDX_W;
  localparam int unsigned MobW = canmob_pkg::MOB_W;

  // configuration
  logic auto_inc_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, auto_inc_q} : '0;

  // item register
  logic                            pend_valid_q;
  logic [canmob_pkg::OP_W-1:0]     p_op_q;
  logic [MobW-1:0]                 p_mob_q;
  logic [canmob_pkg::MODE_W-1:0]   p_mode_q;
  logic [LenW-1:0]                 p_len_q;
  logic [IdW-1:0]                  p_id_q;
  logic [IdW-1:0]                  p_mask_q;
  logic                            in_acc;
  logic                            fire;

  // view and bank state
  logic [MobW-1:0]               page_q, page_d;
  logic [IdW-1:0]                vid_q, vid_d;
  logic [IdW-1:0]                vmask_q, vmask_d;
  logic [LenW-1:0]               vlen_q, vlen_d;
  logic [canmob_pkg::MODE_W-1:0] vmode_q, vmode_d;
  logic [IxW-1:0]                vidx_q, vidx_d;
  logic                          busy_q, busy_d;

  // output register
  logic                   out_valid_q;
  canmob_pkg::event_e     ev_q, ev_d;
  logic [MobW-1:0]        hit_q, hit_d;
  logic [IdW-1:0]         oid_q, oid_d;
  logic [LenW-1:0]        olen_q, olen_d;

  canmob_pkg::req_t    req;
  canmob_pkg::commit_t commit;
  canmob_pkg::chain_t  chain [NUM_OBJECTS+1];
  logic                query;

  assign s_axis_tready = !pend_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign fire          = pend_valid_q && (!out_valid_q || m_axis_tready);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = ev_q;
  assign m_axis_tdata  = {2'b00, vidx_q, busy_q, olen_q, oid_q, hit_q};

  assign req.sel_mob = p_mob_q;
  assign req.rx_id   = p_id_q;
  assign chain[0]    = '0;

  for (genvar g = 0; g < NUM_OBJECTS; g++) begin : g_cell
    canmob_cell #(
      .Idx(g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .req_i   (req),
      .commit_i(commit),
      .chain_i (chain[g]),
      .chain_o (chain[g+1])
    );
  end

  always_comb begin
    page_d       = page_q;
    vid_d        = vid_q;
    vmask_d      = vmask_q;
    vlen_d       = vlen_q;
    vmode_d      = vmode_q;
    vidx_d       = vidx_q;
    busy_d       = busy_q;
    ev_d         = canmob_pkg::EV_DONE;
    hit_d        = page_q;
    query        = 1'b0;
    commit.we    = 1'b0;
    commit.page  = page_q;
    commit.entry = '{id: vid_q, mask: vmask_q, length: vlen_q, mode: vmode_q,
                     index: vidx_q};
    unique case (p_op_q)
      canmob_pkg::OP_SELECT: begin
        if (int'(p_mob_q) < int'(NUM_OBJECTS)) begin
          commit.we = fire;
          page_d    = p_mob_q;
          if (p_mob_q != page_q) begin
            vid_d   = chain[NUM_OBJECTS].sel.id;
            vmask_d = chain[NUM_OBJECTS].sel.mask;
            vlen_d  = chain[NUM_OBJECTS].sel.length;
            vmode_d = chain[NUM_OBJECTS].sel.mode;
            vidx_d  = chain[NUM_OBJECTS].sel.index;
          end
        end
        hit_d = page_d;
      end
      canmob_pkg::OP_CONFIG: begin
        vmode_d             = p_mode_q;
        vlen_d              = p_len_q;
        commit.we           = fire;
        commit.entry.mode   = p_mode_q;
        commit.entry.length = p_len_q;
        if (p_mode_q == canmob_pkg::MODE_TX) begin
          busy_d = 1'b1;
          ev_d   = canmob_pkg::EV_TX;
        end
      end
      canmob_pkg::OP_ID: vid_d = p_id_q;
      canmob_pkg::OP_MASK: vmask_d = p_mask_q;
      canmob_pkg::OP_DATA: begin
        if (auto_inc_q) begin
          vidx_d = (vidx_q == IxW'(DATA_BYTES - 1)) ? '0 : vidx_q + 1'b1;
        end
      end
      canmob_pkg::OP_RECV: begin
        ev_d  = canmob_pkg::EV_MISS;
        hit_d = '0;
        if (chain[NUM_OBJECTS].found) begin
          vlen_d = p_len_q;
          vid_d  = p_id_q;
          ev_d   = canmob_pkg::EV_HIT;
          hit_d  = chain[NUM_OBJECTS].idx[MobW-1:0];
        end
      end
      canmob_pkg::OP_QUERY: begin
        ev_d  = canmob_pkg::EV_SEND;
        hit_d = p_mob_q;
        query = 1'b1;
      end
      default: ;
    endcase
    oid_d  = query ? chain[NUM_OBJECTS].sel.id : vid_d;
    olen_d = query ? chain[NUM_OBJECTS].sel.length : vlen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_inc_q   <= 1'b1;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      page_q       <= '0;
      vid_q        <= '0;
      vmask_q      <= '0;
      vlen_q       <= '0;
      vmode_q      <= '0;
      vidx_q       <= '0;
      busy_q       <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == 1'b0)) begin
        auto_inc_q <= pwdata[0];
      end
      if (in_acc) begin
        pend_valid_q <= 1'b1;
      end else if (fire) begin
        pend_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        page_q      <= page_d;
        vid_q       <= vid_d;
        vmask_q     <= vmask_d;
        vlen_q      <= vlen_d;
        vmode_q     <= vmode_d;
        vidx_q      <= vidx_d;
        busy_q      <= busy_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_op_q   <= s_axis_tuser;
      p_mob_q  <= s_axis_tdata[2:0];
      p_mode_q <= s_axis_tdata[4:3];
      p_len_q  <= s_axis_tdata[8:5];
      p_id_q   <= s_axis_tdata[19:9];
      p_mask_q <= s_axis_tdata[30:20];
    end
    if (fire) begin
      ev_q   <= ev_d;
      hit_q  <= hit_d;
      oid_q  <= oid_d;
      olen_q <= olen_d;
    end
  end

  a_pend_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid_q && out_valid_q && !m_axis_tready) |=> pend_valid_q)
    else $error("pending item dropped while output stalled");

  a_busy_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> busy_q)
    else $error("tx busy flag cleared");

  a_page_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(page_q) < int'(NUM_OBJECTS))
    else $error("current page out of range");

  a_tx_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (ev_q == canmob_pkg::EV_TX)) |-> busy_q)
    else $error("transmit request without busy flag");

endmodule

FILE: sim/tb_can_message_object_bank.sv
// ----------------------------------------------------------------------------
// tb_can_message_object_bank: self-checking bench for the message object bank
// Drives operation items through the input stream and the auto increment
// register through the APB port. A scoreboard keeps its own model of the
// object table and paged view, predicts the result of every accepted item
// and compares each result field by field. Runs a directed pass, then random
// phases with different idle patterns and register settings.
// ----------------------------------------------------------------------------
module tb_can_message_object_bank;

  localparam int unsigned NUM_MOBS    = 6;
  localparam int unsigned NUM_DATA    = 8;
  localparam logic [2:0]  OP_UNUSED   = 3'd7;
  localparam logic [2:0]  REG_AUTO_INC = 3'd0;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 430;

  typedef struct packed {
    logic [canmob_pkg::EV_W-1:0]  ev;
    logic [canmob_pkg::MOB_W-1:0] mob;
    logic [canmob_pkg::ID_W-1:0]  id;
    logic [canmob_pkg::LEN_W-1:0] len;
    logic                         busy;
    logic [canmob_pkg::IDX_W-1:0] idx;
  } bank_result_t;

  class mob_bank_scoreboard;
    canmob_pkg::entry_t            objects[NUM_MOBS];
    logic [canmob_pkg::MOB_W-1:0]  page;
    logic [canmob_pkg::LEN_W-1:0]  v_len;
    logic [canmob_pkg::MODE_W-1:0] v_mode;
    logic [canmob_pkg::IDX_W-1:0]  v_idx;
    logic [canmob_pkg::ID_W-1:0]   v_id;
    logic [canmob_pkg::ID_W-1:0]   v_mask;
    logic                          busy;
    logic                          auto_inc;
    bank_result_t                  pending_results[$];
    int                            fails;

    function new();
      foreach (objects[i]) objects[i] = '0;
      page     = '0;
      v_len    = '0;
      v_mode   = '0;
      v_idx    = '0;
      v_id     = '0;
      v_mask   = '0;
      busy     = 1'b0;
      auto_inc = 1'b1;
      fails    = 0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      fails++;
    endtask

    function void store_view();
      if (page < NUM_MOBS) objects[page] = {v_id, v_mask, v_len, v_mode, v_idx};
    endfunction

    function void note_item(logic [canmob_pkg::OP_W-1:0] op, logic [31:0] data);
      logic [canmob_pkg::MOB_W-1:0]  mob;
      logic [canmob_pkg::MODE_W-1:0] mode;
      logic [canmob_pkg::LEN_W-1:0]  len;
      logic [canmob_pkg::ID_W-1:0]   fid;
      logic [canmob_pkg::ID_W-1:0]   fmask;
      logic [canmob_pkg::ID_W-1:0]   qid;
      logic [canmob_pkg::LEN_W-1:0]  qlen;
      bank_result_t                  r;
      bit                            query;
      bit                            found;
      mob   = data[2:0];
      mode  = data[4:3];
      len   = data[8:5];
      fid   = data[19:9];
      fmask = data[30:20];
      qid   = '0;
      qlen  = '0;
      query = 1'b0;
      found = 1'b0;
      r     = '0;
      r.ev  = canmob_pkg::EV_DONE;
      r.mob = page;
      case (op)
        canmob_pkg::OP_SELECT: begin
          if (mob < NUM_MOBS) begin
            store_view();
            page   = mob;
            v_id   = objects[mob].id;
            v_mask = objects[mob].mask;
            v_len  = objects[mob].length;
            v_mode = objects[mob].mode;
            v_idx  = objects[mob].index;
          end
          r.mob = page;
        end
        canmob_pkg::OP_CONFIG: begin
          v_mode = mode;
          v_len  = len;
          store_view();
          if (mode == canmob_pkg::MODE_TX) begin
            busy = 1'b1;
            r.ev = canmob_pkg::EV_TX;
          end
        end
        canmob_pkg::OP_ID:   v_id = fid;
        canmob_pkg::OP_MASK: v_mask = fmask;
        canmob_pkg::OP_DATA: begin
          if (auto_inc) v_idx = canmob_pkg::IDX_W'((v_idx + 1) % NUM_DATA);
        end
        canmob_pkg::OP_RECV: begin
          r.ev  = canmob_pkg::EV_MISS;
          r.mob = '0;
          for (int i = 0; i < NUM_MOBS; i++) begin
            if (!found && objects[i].mode == canmob_pkg::MODE_RX &&
                (fid & objects[i].mask) == (objects[i].id & objects[i].mask)) begin
              found = 1'b1;
              v_len = len;
              v_id  = fid;
              r.ev  = canmob_pkg::EV_HIT;
              r.mob = canmob_pkg::MOB_W'(i);
            end
          end
        end
        canmob_pkg::OP_QUERY: begin
          r.ev  = canmob_pkg::EV_SEND;
          r.mob = mob;
          query = 1'b1;
          if (mob < NUM_MOBS) begin
            qid  = objects[mob].id;
            qlen = objects[mob].length;
          end
        end
        default: ;
      endcase
      r.id   = query ? qid : v_id;
      r.len  = query ? qlen : v_len;
      r.busy = busy;
      r.idx  = v_idx;
      pending_results.push_back(r);
    endfunction

    task compare_field(string name, logic [10:0] got, logic [10:0] want);
      if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    task check_result(logic [canmob_pkg::EV_W-1:0] ev, logic [23:0] data);
      bank_result_t want;
      if (pending_results.size() == 0) begin
        report("result with no item pending");
      end else begin
        want = pending_results.pop_front();
        compare_field("event", 11'(ev), 11'(want.ev));
        compare_field("hit_mob", 11'(data[2:0]), 11'(want.mob));
        compare_field("out_id", data[13:3], want.id);
        compare_field("out_length", 11'(data[17:14]), 11'(want.len));
        compare_field("tx_busy", 11'(data[18]), 11'(want.busy));
        compare_field("view_index", 11'(data[21:19]), 11'(want.idx));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mob_bank_scoreboard sb;
  int unsigned feed_idle_pct;
  int unsigned drain_stall_pct;
  int unsigned hold_req;
  int unsigned hold_ack;

  can_message_object_bank i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tvalid,
    .s_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tuser, s_axis_tdata);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_ack) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_ack = hold_req;
      end
      m_axis_tready = ($urandom_range(99) >= drain_stall_pct);
    end
  end

  initial begin
    #5000000;
    $display("can_message_object_bank regression: fail");
    $finish;
  end

  function automatic logic [31:0] pack_fields(logic [2:0] mob, logic [1:0] mode,
                                               logic [3:0] len, logic [10:0] id,
                                               logic [10:0] mask);
    return {1'b0, mask, id, len, mode, mob};
  endfunction

  task automatic send_item(logic [2:0] op, logic [31:0] data);
    @(negedge clk_i);
    if ($urandom_range(99) < feed_idle_pct) begin
      s_axis_tvalid = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < feed_idle_pct);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apb_check(logic [2:0] addr, logic want);
    logic [31:0] got;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got[0] !== want) sb.report($sformatf("auto_increment read %0b, expected %0b", got[0], want));
  endtask

  task automatic set_auto_inc(logic value);
    apb_write(REG_AUTO_INC, {31'b0, value});
    sb.auto_inc = value;
    apb_check(REG_AUTO_INC, value);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // random mix, with an occasional run that sets up one object, mostly for reception
  task automatic send_random(int unsigned count);
    logic [31:0] data;
    logic [2:0]  op;
    logic [10:0] m;
    int unsigned pick;
    int unsigned j;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      data     = $urandom;
      data[31] = 1'b0;
      if ($urandom_range(99) < 12) begin
        data[2:0] = 3'($urandom_range(NUM_MOBS - 1));
        send_item(canmob_pkg::OP_SELECT, data);
        data = $urandom & 32'h7fff_ffff;
        send_item(canmob_pkg::OP_ID, data);
        data = $urandom & 32'h7fff_ffff;
        if ($urandom_range(1)) data[30:20] = data[30:20] & 11'h7f0;
        send_item(canmob_pkg::OP_MASK, data);
        data = $urandom & 32'h7fff_ffff;
        data[4:3] = ($urandom_range(3) != 0) ? canmob_pkg::MODE_RX : 2'($urandom_range(3));
        send_item(canmob_pkg::OP_CONFIG, data);
        sent += 4;
      end else begin
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0) data[2:0] = 3'($urandom_range(7, NUM_MOBS));
        else data[2:0] = 3'($urandom_range(NUM_MOBS - 1));
        if (pick < 12) begin
          op = canmob_pkg::OP_SELECT;
        end else if (pick < 24) begin
          op = canmob_pkg::OP_CONFIG;
          if ($urandom_range(1)) data[4:3] = canmob_pkg::MODE_RX;
        end else if (pick < 32) begin
          op = canmob_pkg::OP_ID;
        end else if (pick < 40) begin
          op = canmob_pkg::OP_MASK;
          case ($urandom_range(3))
            0: data[30:20] = 11'h7ff;
            1: data[30:20] = 11'h000;
            2: data[30:20] = data[30:20] & 11'h7f0;
            default: ;
          endcase
        end else if (pick < 56) begin
          op = canmob_pkg::OP_DATA;
        end else if (pick < 86) begin
          op = canmob_pkg::OP_RECV;
          if ($urandom_range(99) < 60) begin
            j = $urandom_range(NUM_MOBS - 1);
            m = sb.objects[j].mask;
            data[19:9] = (sb.objects[j].id & m) | (11'($urandom) & ~m);
          end
        end else if (pick < 97) begin
          op = canmob_pkg::OP_QUERY;
        end else begin
          op = OP_UNUSED;
        end
        send_item(op, data);
        sent++;
      end
    end
  endtask

  initial begin
    sb              = new();
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    feed_idle_pct   = 0;
    drain_stall_pct = 0;
    hold_req        = 0;
    hold_ack        = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    apb_check(REG_AUTO_INC, 1'b1);

    // empty bank, out of range pages and queries, unused code
    send_item(canmob_pkg::OP_RECV, pack_fields(3'd0, 2'd0, 4'd0, 11'h000, 11'h000));
    send_item(canmob_pkg::OP_QUERY, pack_fields(3'd7, 2'd3, 4'd15, 11'h7ff, 11'h7ff));
    send_item(OP_UNUSED, pack_fields(3'd7, 2'd3, 4'd15, 11'h7ff, 11'h7ff));
    send_item(canmob_pkg::OP_SELECT, pack_fields(3'd6, 2'd0, 4'd0, 11'h000, 11'h000));
    // page 0 as receiver with full mask
    send_item(canmob_pkg::OP_ID, pack_fields(3'd0, 2'd0, 4'd0, 11'h7ff, 11'h000));
    send_item(canmob_pkg::OP_MASK, pack_fields(3'd0, 2'd0, 4'd0, 11'h000, 11'h7ff));
    send_item(canmob_pkg::OP_CONFIG,
              pack_fields(3'd0, canmob_pkg::MODE_RX, 4'd15, 11'h000, 11'h000));
    send_item(canmob_pkg::OP_RECV, pack_fields(3'd0, 2'd0, 4'd15, 11'h7ff, 11'h000));
    send_item(canmob_pkg::OP_RECV, pack_fields(3'd0, 2'd0, 4'd0, 11'h000, 11'h000));
    // page 1: transmit sets busy, then frame buffer and disable
    send_item(canmob_pkg::OP_SELECT, pack_fields(3'd1, 2'd0, 4'd0, 11'h000, 11'h000));
    send_item(canmob_pkg::OP_ID, pack_fields(3'd0, 2'd0, 4'd0, 11'h000, 11'h000));
    send_item(canmob_pkg::OP_MASK, pack_fields(3'd0, 2'd0, 4'd0, 11'h000, 11'h000));
    send_item(canmob_pkg::OP_CONFIG,
              pack_fields(3'd0, canmob_pkg::MODE_TX, 4'd0, 11'h000, 11'h000));
    send_item(canmob_pkg::OP_CONFIG,
              pack_fields(3'd0, canmob_pkg::MODE_BUF, 4'd7, 11'h000, 11'h000));
    send_item(canmob_pkg::OP_CONFIG,
              pack_fields(3'd0, canmob_pkg::MODE_OFF, 4'd15, 11'h000, 11'h000));
    send_item(canmob_pkg::OP_QUERY, pack_fields(3'd0, 2'd0, 4'd0, 11'h000, 11'h000));
    // data index wraps after eight writes
    repeat (8) begin
      send_item(canmob_pkg::OP_DATA, pack_fields(3'd0, 2'd0, 4'd0, 11'h000, 11'h000));
    end
    wait_idle();

    // no idling, with a long receiver hold-off
    hold_req++;
    send_random(PHASE_ITEMS);
    wait_idle();

    set_auto_inc(1'b0);
    feed_idle_pct   = 85;
    drain_stall_pct = 0;
    send_random(PHASE_ITEMS);
    wait_idle();

    set_auto_inc(1'b1);
    feed_idle_pct   = 0;
    drain_stall_pct = 85;
    send_random(PHASE_ITEMS);
    wait_idle();

    set_auto_inc(1'b0);
    feed_idle_pct   = 18;
    drain_stall_pct = 18;
    send_random(PHASE_ITEMS);
    wait_idle();

    if (sb.pending_results.size() != 0) sb.report("items left without a result");
    if (sb.fails == 0) begin
      $display("can_message_object_bank regression: pass");
    end else begin
      $display("can_message_object_bank regression: fail");
    end
    $finish;
  end

endmodule

FILE: can_message_object_bank.f
rtl/canmob_pkg.sv
rtl/canmob_cell.sv
rtl/can_message_object_bank.sv
sim/tb_can_message_object_bank.sv
